[hw/rtl/i2crt_pkg.sv]
package i2crt_pkg;

    localparam int MAX_BYTES = 16;
    localparam int IDX_W = $clog2(MAX_BYTES);
    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_QUEUE = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ADDR_NAK = 2'd1;
    localparam logic [1:0] STAT_DATA_NAK = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_ADDR_W, ST_ACK_ADDR_W, ST_REG, ST_ACK_REG,
        ST_DATA, ST_ACK_DATA, ST_RESTART, ST_ADDR_R, ST_ACK_ADDR_R,
        ST_RX, ST_TX_ACK, ST_STOP
    } seq_state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic [7:0] data_byte;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic [1:0] status;
    } out_item_t;

endpackage

[hw/rtl/i2c_master_register_transfer_unit.sv]
// I2C master, register read/write transfers.
// Input channel (in_valid/in_ready/in_data): each item is a command.
//   cmd 1 queues a write byte (ignored when busy or when the queue is full),
//   cmd 2/3 starts a write/read with device address, register and length,
//   cmd 0 is a bus tick: one phase of SCL/SDA advances and SDA is sampled.
// Output channel (out_valid/out_ready/out_data): exactly one result per
//   item, giving the SCL/SDA levels after it, busy, a received byte,
//   the done strobe and the transfer status.
// Structure: a two-entry input queue feeds the bus sequencer, which
//   writes one result register. One item per cycle is sustained while
//   the receiver takes results; an accepted item passes through the
//   queue, then the result register, before its result shows.
// When the receiver stalls, the result register holds and the queue
//   fills; in_ready falls once both queue entries are taken.
// Reset: bus released (SCL=SDA=1), idle, status ok, write queue empty.
//   The write byte store is not cleared; a transfer longer than the
//   queued data reads stale contents.
module i2c_master_register_transfer_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2crt_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2crt_pkg::out_item_t out_data
);
    import i2crt_pkg::*;

    in_item_t q_data;
    logic     q_valid, q_ready;

    i2crt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    i2crt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[hw/rtl/i2crt_fifo.sv]
module i2crt_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2crt_pkg::in_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output i2crt_pkg::in_item_t out_data
);
    import i2crt_pkg::*;

    // two-entry queue between front and back
    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 && !pop |=> cnt_reg == 2'd2)
        else $error("queue lost an entry");
    a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointer mismatch");

endmodule

[hw/rtl/i2crt_seq.sv]
module i2crt_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  i2crt_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2crt_pkg::out_item_t out_data
);
    import i2crt_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [2:0]          bit_reg, bit_next;
    logic [CNT_W-1:0]    byte_reg, byte_next;
    logic [7:0]          sh_reg, sh_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                rd_mode_reg, rd_mode_next;
    logic [1:0]          stat_reg, stat_next;
    logic [6:0]          dev_reg, dev_next;
    logic [7:0]          regad_reg, regad_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic                scl_reg, scl_next, sda_reg, sda_next;
    logic [7:0]          buf_mem [MAX_BYTES];
    logic                buf_we;
    logic [IDX_W-1:0]    buf_ra;
    logic [7:0]          buf_rd;
    logic                rxv, done;
    logic [7:0]          rxb;
    logic                fire;
    logic                obuf_valid_reg;
    out_item_t           obuf_reg;
    logic                msb, last;
    logic [CNT_W-1:0]    byte_inc;
    logic [CNT_W:0]      last_sum;

    assign in_ready  = !obuf_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = obuf_valid_reg;
    assign out_data  = obuf_reg;

    assign msb      = sh_reg[7];
    assign byte_inc = byte_reg + 1'b1;
    assign last_sum = {1'b0, byte_reg} + 1'b1;
    assign last     = (last_sum >= {1'b0, len_reg});
    assign buf_rd   = buf_mem[buf_ra];

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[fill_reg[IDX_W-1:0]] <= in_data.data_byte;
        end
    end

    always_comb
    begin
        state_next = state_reg; phase_next = phase_reg; bit_next = bit_reg;
        byte_next = byte_reg; sh_next = sh_reg; fill_next = fill_reg;
        rd_mode_next = rd_mode_reg; stat_next = stat_reg; dev_next = dev_reg;
        regad_next = regad_reg; len_next = len_reg; scl_next = scl_reg;
        sda_next = sda_reg; buf_we = 1'b0; buf_ra = '0;
        rxv = 1'b0; rxb = 8'd0; done = 1'b0;
        if (fire)
        begin
            if (in_data.cmd != CMD_TICK)
            begin
                if (state_reg == ST_IDLE)
                begin
                    if (in_data.cmd == CMD_QUEUE)
                    begin
                        if (fill_reg < CNT_W'(MAX_BYTES))
                        begin
                            buf_we    = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rd_mode_next = (in_data.cmd == CMD_READ);
                        dev_next     = in_data.dev_addr;
                        regad_next   = in_data.reg_addr;
                        len_next     = (in_data.byte_count > 5'(MAX_BYTES)) ?
                                       CNT_W'(MAX_BYTES) : CNT_W'(in_data.byte_count);
                        stat_next    = STAT_OK;
                        fill_next    = '0;
                        phase_next   = 2'd0;
                        bit_next     = 3'd0;
                        byte_next    = '0;
                        sh_next      = 8'd0;
                        state_next   = ST_START;
                        scl_next     = 1'b1;
                        sda_next     = 1'b1;
                    end
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE: ;
                    ST_START:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b1; sda_next = 1'b1; phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b1; sda_next = 1'b0; phase_next = 2'd0;
                            bit_next = 3'd0; sh_next = {dev_reg, 1'b0};
                            state_next = ST_ADDR_W;
                        end
                    end
                    ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R:
                    begin
                        sda_next = msb;
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b0; phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b1; phase_next = 2'd0;
                            sh_next = {sh_reg[6:0], 1'b0};
                            if (bit_reg == 3'd7)
                            begin
                                bit_next = 3'd0;
                                unique case (state_reg)
                                    ST_ADDR_W: state_next = ST_ACK_ADDR_W;
                                    ST_REG:    state_next = ST_ACK_REG;
                                    ST_DATA:   state_next = ST_ACK_DATA;
                                    default:   state_next = ST_ACK_ADDR_R;
                                endcase
                            end
                            else
                            begin
                                bit_next = bit_reg + 1'b1;
                            end
                        end
                    end
                    ST_ACK_ADDR_W, ST_ACK_REG, ST_ACK_DATA, ST_ACK_ADDR_R:
                    begin
                        sda_next = 1'b1;
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b0; phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b1; phase_next = 2'd0;
                            unique case (state_reg)
                                ST_ACK_ADDR_W:
                                begin
                                    if (in_data.sda_in)
                                    begin
                                        stat_next = STAT_ADDR_NAK; state_next = ST_STOP;
                                    end
                                    else
                                    begin
                                        sh_next = regad_reg; state_next = ST_REG;
                                    end
                                end
                                ST_ACK_REG:
                                begin
                                    if (rd_mode_reg) state_next = ST_RESTART;
                                    else if (len_reg == '0) state_next = ST_STOP;
                                    else
                                    begin
                                        byte_next = '0; buf_ra = '0;
                                        sh_next = buf_rd; state_next = ST_DATA;
                                    end
                                end
                                ST_ACK_DATA:
                                begin
                                    if (in_data.sda_in)
                                    begin
                                        stat_next = STAT_DATA_NAK; state_next = ST_STOP;
                                    end
                                    else
                                    begin
                                        byte_next = byte_inc;
                                        if (byte_inc >= len_reg) state_next = ST_STOP;
                                        else
                                        begin
                                            buf_ra = byte_inc[IDX_W-1:0];
                                            sh_next = buf_rd; state_next = ST_DATA;
                                        end
                                    end
                                end
                                default:
                                begin
                                    byte_next = '0;
                                    if (len_reg == '0) state_next = ST_STOP;
                                    else
                                    begin
                                        sh_next = 8'd0; bit_next = 3'd0;
                                        state_next = ST_RX;
                                    end
                                end
                            endcase
                        end
                    end
                    ST_RESTART:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b0; sda_next = 1'b1; phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            scl_next = 1'b1; sda_next = 1'b1; phase_next = 2'd2;
                        end
                        else
                        begin
                            scl_next = 1'b1; sda_next = 1'b0; phase_next = 2'd0;
                            bit_next = 3'd0; sh_next = {dev_reg, 1'b1};
                            state_next = ST_ADDR_R;
                        end
                    end
                    ST_RX:
                    begin
                        sda_next = 1'b1;
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b0; phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b1; phase_next = 2'd0;
                            sh_next = {sh_reg[6:0], in_data.sda_in};
                            if (bit_reg == 3'd7)
                            begin
                                bit_next = 3'd0; rxv = 1'b1;
                                rxb = {sh_reg[6:0], in_data.sda_in};
                                state_next = ST_TX_ACK;
                            end
                            else
                            begin
                                bit_next = bit_reg + 1'b1;
                            end
                        end
                    end
                    ST_TX_ACK:
                    begin
                        sda_next = last;
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b0; phase_next = 2'd1;
                        end
                        else
                        begin
                            scl_next = 1'b1; phase_next = 2'd0;
                            byte_next = byte_inc;
                            if (last) state_next = ST_STOP;
                            else
                            begin
                                sh_next = 8'd0; state_next = ST_RX;
                            end
                        end
                    end
                    ST_STOP:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            scl_next = 1'b0; sda_next = 1'b0; phase_next = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            scl_next = 1'b1; sda_next = 1'b0; phase_next = 2'd2;
                        end
                        else
                        begin
                            scl_next = 1'b1; sda_next = 1'b1; phase_next = 2'd0;
                            done = 1'b1; state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE; phase_next = 2'd0;
                        scl_next = 1'b1; sda_next = 1'b1;
                    end
                endcase
                // the bus phases that move to stop always restart at phase 0
                if (state_next == ST_STOP && state_reg != ST_STOP) phase_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE; phase_reg <= 2'd0; bit_reg <= 3'd0;
            byte_reg <= '0; sh_reg <= 8'd0; fill_reg <= '0; rd_mode_reg <= 1'b0;
            stat_reg <= STAT_OK; dev_reg <= 7'd0; regad_reg <= 8'd0;
            len_reg <= '0; scl_reg <= 1'b1; sda_reg <= 1'b1;
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; phase_reg <= phase_next; bit_reg <= bit_next;
            byte_reg <= byte_next; sh_reg <= sh_next; fill_reg <= fill_next;
            rd_mode_reg <= rd_mode_next; stat_reg <= stat_next; dev_reg <= dev_next;
            regad_reg <= regad_next; len_reg <= len_next;
            scl_reg <= scl_next; sda_reg <= sda_next;
            if (fire) obuf_valid_reg <= 1'b1;
            else if (out_ready) obuf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            obuf_reg.scl_level <= scl_next;
            obuf_reg.sda_level <= sda_next;
            obuf_reg.busy_res  <= (state_next != ST_IDLE);
            obuf_reg.rx_valid  <= rxv;
            obuf_reg.rx_byte   <= rxb;
            obuf_reg.done_res  <= done;
            obuf_reg.status    <= stat_next;
        end
    end

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_BYTES))
        else $error("write queue overfilled");
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> scl_reg && sda_reg)
        else $error("bus not released while idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg) && $stable(phase_reg))
        else $error("sequencer moved without an item");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CNT_W'(MAX_BYTES))
        else $error("length beyond limit");

endmodule
